FILE: hw/rtl/binary_digits_base_k_mod_prime_unit_macros.svh
// assertion macros shared by the rtl of the base-k digit sum unit
// no dependencies; included by the modules that carry assertions
`ifndef BINARY_DIGITS_BASE_K_MOD_PRIME_UNIT_MACROS_SVH
`define BINARY_DIGITS_BASE_K_MOD_PRIME_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define BDK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdk assertion failed");

// next-cycle implication, held off during reset
`define BDK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdk assertion failed");

`endif

FILE: hw/rtl/bdk_pkg.sv
// shared types and constants for the base-k digit sum unit
// no dependencies
`default_nettype none

package bdk_pkg;

  localparam int IN_W         = 64;
  localparam int OUT_W        = 54;
  localparam int REDUCE_STEPS = IN_W;
  localparam int CNT_W        = $clog2(REDUCE_STEPS);

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_REDUCE,
    CMD_ACCUM,
    CMD_MUL_STEP,
    CMD_POWER,
    CMD_RESULT
  } dp_cmd_t;

  typedef struct packed {
    logic bits_zero;
    logic mul_zero;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ACCUM,
    ST_MUL,
    ST_FINISH
  } ctrl_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/binary_digits_base_k_mod_prime_unit.sv
// Reads the set bits of bit_string as a base-k numeral modulo MODULUS and
// returns sum of k^i over set bits i. One item is in work at a time. An item
// is loaded, k_base is reduced modulo MODULUS (one restoring step per bit),
// then for each bit position up to the highest set bit there is one
// accumulate step plus a shift-add multiply by the reduced base, stepping
// through the bit length of that base, and finally the result is published.
// The multiply loop dominates the run time. The result sits in its own
// register, so the next item is accepted while a finished result waits for
// out_ready.
// depends on bdk_pkg, bdk_ctrl, bdk_datapath
`default_nettype none

module binary_digits_base_k_mod_prime_unit
  import bdk_pkg::*;
#(
  parameter longint unsigned MODULUS = 64'd10000000000000061
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IN_W-1:0]   k_base,
  input  wire logic [IN_W-1:0]   bit_string,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [OUT_W-1:0]  power_sum
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bdk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bdk_datapath #(
    .MODULUS (MODULUS)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .k_base     (k_base),
    .bit_string (bit_string),
    .power_sum  (power_sum)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/bdk_datapath.sv
// datapath: base reduction, running power, shift-add modular multiply, sum
// depends on bdk_pkg
`default_nettype none

module bdk_datapath
  import bdk_pkg::*;
#(
  parameter longint unsigned MODULUS = 64'd10000000000000061
) (
  input  wire logic               clk,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  input  wire logic [IN_W-1:0]    k_base,
  input  wire logic [IN_W-1:0]    bit_string,
  output logic      [OUT_W-1:0]   power_sum
);

  localparam int MW = $clog2(MODULUS);
  localparam logic [MW:0] MOD_W = (MW+1)'(MODULUS);

  logic [IN_W-1:0] kshift;
  logic [IN_W-1:0] bits;
  logic [MW-1:0]   base;
  logic [MW-1:0]   sum;
  logic [MW-1:0]   power;
  logic [MW-1:0]   acc;
  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;

  logic [MW:0]     red_t;
  logic [MW-1:0]   red_next;
  logic [MW-1:0]   sum_next;
  logic [MW-1:0]   acc_next;
  logic [MW-1:0]   dbl_next;
  logic [IN_W-1:0] sum_wide;

  // x + y reduced by one conditional subtract; both inputs below the modulus
  function automatic logic [MW-1:0] mod_add(input logic [MW-1:0] x, input logic [MW-1:0] y);
    logic [MW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= MOD_W) begin
      s = s - MOD_W;
    end
    return s[MW-1:0];
  endfunction

  // one restoring step of k mod modulus, msb first
  always_comb begin
    red_t = {base, kshift[IN_W-1]};
    if (red_t >= MOD_W) begin
      red_t = red_t - MOD_W;
    end
    red_next = red_t[MW-1:0];
  end

  assign sum_next = mod_add(sum, power);
  assign acc_next = mod_add(acc, mul_a);
  assign dbl_next = mod_add(mul_a, mul_a);

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        kshift <= k_base;
        bits   <= bit_string;
        base   <= '0;
        sum    <= '0;
        power  <= MW'(1);
      end
      CMD_REDUCE: begin
        base   <= red_next;
        kshift <= {kshift[IN_W-2:0], 1'b0};
      end
      CMD_ACCUM: begin
        if (bits[0]) begin
          sum <= sum_next;
        end
        bits  <= {1'b0, bits[IN_W-1:1]};
        acc   <= '0;
        mul_a <= power;
        mul_b <= base;
      end
      CMD_MUL_STEP: begin
        if (mul_b[0]) begin
          acc <= acc_next;
        end
        mul_a <= dbl_next;
        mul_b <= {1'b0, mul_b[MW-1:1]};
      end
      CMD_POWER: begin
        power <= acc;
      end
      CMD_RESULT: begin
        power_sum <= sum_wide[OUT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign sum_wide         = IN_W'(sum);
  assign status.bits_zero = (bits == '0);
  assign status.mul_zero  = (mul_b == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/bdk_ctrl.sv
// controller: sequences reduction, bit loop and multiply, owns the handshakes
// depends on bdk_pkg and the assertion macro header
`default_nettype none
`include "binary_digits_base_k_mod_prime_unit_macros.svh"

module bdk_ctrl
  import bdk_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = CMD_NOP;
    in_ready       = 1'b0;
    out_valid_next = out_valid & ~out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          cnt_next   = '0;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd      = CMD_REDUCE;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(REDUCE_STEPS - 1)) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (status.bits_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd        = CMD_ACCUM;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status.mul_zero) begin
          cmd        = CMD_POWER;
          state_next = ST_ACCUM;
        end else begin
          cmd = CMD_MUL_STEP;
        end
      end
      ST_FINISH: begin
        // result register is free or being emptied this cycle
        if (!out_valid || out_ready) begin
          cmd            = CMD_RESULT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `BDK_ASSERT_NEXT(a_load_starts_reduce, clk, rst, in_valid && in_ready, (state == ST_REDUCE) && (cnt == '0))
  `BDK_ASSERT_NEXT(a_mul_runs_until_done, clk, rst, (state == ST_MUL) && !status.mul_zero, state == ST_MUL)
  `BDK_ASSERT_NEXT(a_finish_publishes, clk, rst, (state == ST_FINISH) && (!out_valid || out_ready), out_valid && (state == ST_IDLE))

endmodule

`default_nettype wire
